@@ rtl/text_console_engine_assert.svh @@
// Assertion macros for the console engine RTL.
`ifndef TEXT_CONSOLE_ENGINE_ASSERT_SVH
`define TEXT_CONSOLE_ENGINE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Check a property on every clock edge outside reset.
`define TCE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define TCE_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define TCE_ASSERT(label, prop, msg)
`define TCE_ASSERT_ALWAYS(label, prop, msg)

`endif

`endif

@@ rtl/tce_pkg.sv @@
// Types and constants shared by the text console engine.
package tce_pkg;

  localparam logic [1:0] OP_PUT   = 2'd0;
  localparam logic [1:0] OP_SET   = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;
  localparam logic [1:0] OP_READ  = 2'd3;

  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_RETURN    = 8'h0D;
  localparam logic [7:0] CH_BACKSPACE = 8'h08;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] RESET_ATTR   = 8'h07;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] char_code;
    logic [4:0] target_row;
    logic [6:0] target_column;
  } in_req_t;

  typedef struct packed {
    logic [4:0]  cursor_row;
    logic [6:0]  cursor_column;
    logic [15:0] cell_value;
    logic        accepted;
  } out_rsp_t;

  typedef struct packed {
    logic [4:0] row;
    logic [6:0] col;
  } cursor_t;

  // What one request does: new cursor, one optional cell write or read,
  // and whether a scroll or a full clear follows.
  typedef struct packed {
    cursor_t    cursor;
    logic       ok;
    logic       wr_en;
    cursor_t    wr_pos;
    logic [7:0] wr_char;
    logic       scroll;
    logic       clear;
    logic       rd_en;
  } plan_t;

endpackage

@@ rtl/tce_decode.sv @@
// Request decoder: turns one request and the cursor into an action plan.
module tce_decode
  import tce_pkg::*;
#(
  parameter int SCREEN_COLUMNS = 80,
  parameter int SCREEN_ROWS    = 25
) (
  input  in_req_t req,
  input  cursor_t cur,
  output plan_t   plan
);

  localparam logic [4:0] LAST_ROW = 5'(SCREEN_ROWS - 1);
  localparam logic [6:0] LAST_COL = 7'(SCREEN_COLUMNS - 1);

  logic in_range;
  logic at_last_row;
  logic at_last_col;

  assign in_range = ({1'b0, req.target_row} < 6'(SCREEN_ROWS)) &&
                    ({1'b0, req.target_column} < 8'(SCREEN_COLUMNS));
  assign at_last_row = (cur.row == LAST_ROW);
  assign at_last_col = (cur.col == LAST_COL);

  always_comb begin
    plan         = '0;
    plan.cursor  = cur;
    plan.ok      = 1'b1;
    plan.wr_pos  = cur;
    plan.wr_char = CH_SPACE;
    unique case (req.operation)
      OP_PUT: begin
        case (req.char_code)
          CH_NEWLINE: begin
            plan.cursor.col = '0;
            if (at_last_row) begin
              plan.scroll = 1'b1;
            end else begin
              plan.cursor.row = cur.row + 5'd1;
            end
          end
          CH_RETURN: begin
            plan.cursor.col = '0;
          end
          CH_BACKSPACE: begin
            if (cur.col != '0) begin
              plan.cursor.col = cur.col - 7'd1;
              plan.wr_en      = 1'b1;
              plan.wr_pos.col = cur.col - 7'd1;
            end
          end
          default: begin
            plan.wr_en   = 1'b1;
            plan.wr_char = req.char_code;
            if (at_last_col) begin
              plan.cursor.col = '0;
              if (at_last_row) begin
                plan.scroll = 1'b1;
              end else begin
                plan.cursor.row = cur.row + 5'd1;
              end
            end else begin
              plan.cursor.col = cur.col + 7'd1;
            end
          end
        endcase
      end
      OP_SET: begin
        if (in_range) begin
          plan.cursor.row = req.target_row;
          plan.cursor.col = req.target_column;
        end else begin
          plan.ok = 1'b0;
        end
      end
      OP_CLEAR: begin
        plan.clear  = 1'b1;
        plan.cursor = '0;
      end
      OP_READ: begin
        if (in_range) begin
          plan.rd_en = 1'b1;
        end else begin
          plan.ok = 1'b0;
        end
      end
    endcase
  end

endmodule

@@ rtl/text_console_engine.sv @@
// Top level of the text console engine: screen store, sequencer, ports.
//
// A text console holding a SCREEN_ROWS x SCREEN_COLUMNS grid of 16-bit cells
// (character low byte, attribute high byte) and a cursor.
// Input channel (in_valid/in_stall/in_data): one request per handshake, taken
// only while the sequencer is idle. Output channel (out_valid/out_stall/
// out_data): exactly one response per request, reporting the cursor after it.
// Config channel (cfg_valid/cfg_ready/cfg_data): sets the attribute byte used
// for written characters and blanks; always ready.
// A put, set cursor or out-of-range request passes through the EXEC and RESP
// states, a cell read through EXEC, READ and RESP; the response is loaded in
// RESP once the output slot frees, and the next request is taken only after
// that, back in idle. The store has one write port and one read port.
// Scroll copies the store up one row, one cell a cycle through the read
// port, then blanks the bottom row. Clear screen walks every cell.
// Reset: the store is swept to grey blanks (0x0720), one cell a cycle, with
// in_stall high throughout.
// A stalled response sits in the output register; one further request may be
// taken and worked meanwhile, and its response waits until the slot frees.
module text_console_engine
  import tce_pkg::*;
#(
  parameter int SCREEN_COLUMNS = 80,
  parameter int SCREEN_ROWS    = 25
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_req_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output out_rsp_t out_data,
  input  logic     cfg_valid,
  output logic     cfg_ready,
  input  logic [7:0] cfg_data
);

`include "text_console_engine_assert.svh"

  localparam int CELLS = SCREEN_ROWS * SCREEN_COLUMNS;
  localparam int AW    = $clog2(CELLS);

  localparam logic [AW-1:0] COPY_END  = AW'(CELLS - SCREEN_COLUMNS);
  localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);
  localparam logic [AW-1:0] ROW_STEP  = AW'(SCREEN_COLUMNS);

  localparam logic [2:0] S_FILL   = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_EXEC   = 3'd2;
  localparam logic [2:0] S_SCROLL = 3'd3;
  localparam logic [2:0] S_READ   = 3'd4;
  localparam logic [2:0] S_RESP   = 3'd5;

  function automatic logic [AW-1:0] cell_addr(input cursor_t pos);
    return AW'(int'(pos.row) * SCREEN_COLUMNS + int'(pos.col));
  endfunction

  // screen store
  logic [15:0] screen_mem [CELLS];
  logic [15:0] mem_rdata_r;
  logic        mem_we;
  logic [AW-1:0] mem_waddr;
  logic [15:0] mem_wdata;
  logic        mem_re;
  logic [AW-1:0] mem_raddr;

  // sequencer and datapath
  logic [2:0]    state_r, state_nxt;
  logic          init_r;
  logic [AW-1:0] cnt_r;
  logic          pend_v_r;
  logic [AW-1:0] pend_addr_r;
  logic [15:0]   blank_r;
  logic [7:0]    attr_r;
  in_req_t       req_r;
  cursor_t       cur_r;
  logic          ok_r;
  logic [15:0]   cell_r;
  logic          out_valid_r;
  out_rsp_t      out_data_r;
  plan_t         plan;
  logic          in_take;
  logic          out_free;

  tce_decode #(
    .SCREEN_COLUMNS(SCREEN_COLUMNS),
    .SCREEN_ROWS   (SCREEN_ROWS)
  ) u_decode (
    .req (req_r),
    .cur (cur_r),
    .plan(plan)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign cfg_ready = 1'b1;

  // Store port usage per state.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cnt_r;
    mem_wdata = blank_r;
    mem_re    = 1'b0;
    mem_raddr = cnt_r + ROW_STEP;
    unique case (state_r)
      S_FILL: begin
        mem_we = 1'b1;
      end
      S_EXEC: begin
        mem_we    = plan.wr_en;
        mem_waddr = cell_addr(plan.wr_pos);
        mem_wdata = {attr_r, plan.wr_char};
        mem_re    = plan.rd_en;
        mem_raddr = cell_addr({req_r.target_row, req_r.target_column});
      end
      S_SCROLL: begin
        // read one row ahead, write back what came out last cycle
        mem_re    = (cnt_r < COPY_END);
        mem_we    = pend_v_r;
        mem_waddr = pend_addr_r;
        mem_wdata = mem_rdata_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      screen_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_r <= screen_mem[mem_raddr];
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_FILL: begin
        if (cnt_r == LAST_CELL) begin
          state_nxt = init_r ? S_IDLE : S_RESP;
        end
      end
      S_IDLE: begin
        if (in_take) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (plan.clear) begin
          state_nxt = S_FILL;
        end else if (plan.scroll) begin
          state_nxt = S_SCROLL;
        end else if (plan.rd_en) begin
          state_nxt = S_READ;
        end else begin
          state_nxt = S_RESP;
        end
      end
      S_SCROLL: begin
        if (cnt_r == COPY_END) begin
          state_nxt = S_FILL;
        end
      end
      S_READ: begin
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_FILL;
      init_r      <= 1'b1;
      cnt_r       <= '0;
      pend_v_r    <= 1'b0;
      blank_r     <= {RESET_ATTR, CH_SPACE};
      attr_r      <= RESET_ATTR;
      cur_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        attr_r <= cfg_data;
      end
      // load a response when the slot frees, else drop the one just taken
      if (state_r == S_RESP && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_FILL: begin
          cnt_r <= cnt_r + AW'(1);
          if (cnt_r == LAST_CELL) begin
            init_r <= 1'b0;
          end
        end
        S_IDLE: begin
          if (in_take) begin
            req_r <= in_data;
          end
        end
        S_EXEC: begin
          cur_r    <= plan.cursor;
          ok_r     <= plan.ok;
          cell_r   <= '0;
          pend_v_r <= 1'b0;
          blank_r  <= {attr_r, CH_SPACE};
          cnt_r    <= '0;
        end
        S_SCROLL: begin
          pend_v_r    <= (cnt_r < COPY_END);
          pend_addr_r <= cnt_r;
          if (cnt_r != COPY_END) begin
            cnt_r <= cnt_r + AW'(1);
          end
        end
        S_READ: begin
          cell_r <= mem_rdata_r;
        end
        S_RESP: begin
          if (out_free) begin
            out_data_r.cursor_row    <= cur_r.row;
            out_data_r.cursor_column <= cur_r.col;
            out_data_r.cell_value    <= cell_r;
            out_data_r.accepted      <= ok_r;
          end
        end
        default: begin
        end
      endcase
    end
  end

  `TCE_ASSERT(a_row_in_range, {1'b0, cur_r.row} < 6'(SCREEN_ROWS), "cursor row out of range")
  `TCE_ASSERT(a_col_in_range, {1'b0, cur_r.col} < 8'(SCREEN_COLUMNS), "cursor column out of range")
  `TCE_ASSERT(a_resp_from_resp, $rose(out_valid_r) |-> $past(state_r) == S_RESP, "response loaded outside response state")
  `TCE_ASSERT(a_write_states, mem_we |-> (state_r == S_FILL || state_r == S_EXEC || state_r == S_SCROLL), "store written in a quiet state")
  `TCE_ASSERT(a_scroll_order, (state_r == S_SCROLL && mem_we && mem_re) |-> mem_waddr < mem_raddr, "scroll write overtook its read")

endmodule

@@ tb/sv/tce_console_checker.sv @@
`timescale 1ns / 100ps
// Checker for the text console engine: screen model and response compare.
module tce_console_checker
  import tce_pkg::*;
#(
  parameter int SCREEN_COLUMNS = 80,
  parameter int SCREEN_ROWS    = 25
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  in_req_t    in_data,
  input  logic       out_valid,
  input  logic       out_stall,
  input  out_rsp_t   out_data,
  input  logic       cfg_valid,
  input  logic       cfg_ready,
  input  logic [7:0] cfg_data,
  output int         fail_count,
  output int         pending_count,
  output int         checked_count
);

  localparam int CELLS = SCREEN_COLUMNS * SCREEN_ROWS;

  logic [15:0] screen [CELLS];
  logic [4:0]  row_q;
  logic [6:0]  col_q;
  logic [7:0]  attr_q;
  out_rsp_t    cursor_reports [$];

  int mismatches = 0;
  int compared   = 0;
  int depth      = 0;

  assign fail_count    = mismatches;
  assign pending_count = depth;
  assign checked_count = compared;

  function automatic logic [15:0] blank_cell();
    return {attr_q, CH_SPACE};
  endfunction

  // Move rows up by one and blank the bottom row.
  function automatic void scroll_screen();
    for (int i = 0; i < CELLS - SCREEN_COLUMNS; i++) screen[i] = screen[i + SCREEN_COLUMNS];
    for (int i = CELLS - SCREEN_COLUMNS; i < CELLS; i++) screen[i] = blank_cell();
  endfunction

  function automatic void line_feed();
    col_q = '0;
    if (row_q == SCREEN_ROWS - 1) scroll_screen();
    else row_q = row_q + 5'd1;
  endfunction

  function automatic void put_char(logic [7:0] ch);
    if (ch == CH_NEWLINE) begin
      line_feed();
    end else if (ch == CH_RETURN) begin
      col_q = '0;
    end else if (ch == CH_BACKSPACE) begin
      if (col_q != 0) begin
        col_q = col_q - 7'd1;
        screen[row_q * SCREEN_COLUMNS + col_q] = blank_cell();
      end
    end else begin
      screen[row_q * SCREEN_COLUMNS + col_q] = {attr_q, ch};
      if (col_q == SCREEN_COLUMNS - 1) line_feed();
      else col_q = col_q + 7'd1;
    end
  endfunction

  // Apply one request to the screen model and return the cursor report.
  function automatic out_rsp_t console_effect(in_req_t req);
    out_rsp_t rsp;
    logic     in_grid;
    in_grid = (req.target_row < SCREEN_ROWS) && (req.target_column < SCREEN_COLUMNS);
    rsp = '0;
    rsp.accepted = 1'b1;
    case (req.operation)
      OP_PUT: begin
        put_char(req.char_code);
      end
      OP_SET: begin
        if (in_grid) begin
          row_q = req.target_row;
          col_q = req.target_column;
        end else begin
          rsp.accepted = 1'b0;
        end
      end
      OP_CLEAR: begin
        for (int i = 0; i < CELLS; i++) screen[i] = blank_cell();
        row_q = '0;
        col_q = '0;
      end
      default: begin
        if (in_grid) rsp.cell_value = screen[req.target_row * SCREEN_COLUMNS + req.target_column];
        else rsp.accepted = 1'b0;
      end
    endcase
    rsp.cursor_row    = row_q;
    rsp.cursor_column = col_q;
    return rsp;
  endfunction

  always @(posedge clk) begin
    out_rsp_t want;
    if (!rst_n) begin
      for (int i = 0; i < CELLS; i++) screen[i] = {RESET_ATTR, CH_SPACE};
      row_q  = '0;
      col_q  = '0;
      attr_q = RESET_ATTR;
      cursor_reports.delete();
    end else begin
      if (cfg_valid && cfg_ready) attr_q = cfg_data;
      if (in_valid && !in_stall) cursor_reports.push_back(console_effect(in_data));
      if (out_valid && !out_stall) begin
        if (cursor_reports.size() == 0) begin
          $display("%0t: response with none pending, actual %h", $time, out_data);
          mismatches++;
        end else begin
          want = cursor_reports.pop_front();
          compared++;
          if (out_data.cursor_row !== want.cursor_row) begin
            $display("%0t: cursor_row expected %0d actual %0d",
                     $time, want.cursor_row, out_data.cursor_row);
            mismatches++;
          end
          if (out_data.cursor_column !== want.cursor_column) begin
            $display("%0t: cursor_column expected %0d actual %0d",
                     $time, want.cursor_column, out_data.cursor_column);
            mismatches++;
          end
          if (out_data.cell_value !== want.cell_value) begin
            $display("%0t: cell_value expected %h actual %h",
                     $time, want.cell_value, out_data.cell_value);
            mismatches++;
          end
          if (out_data.accepted !== want.accepted) begin
            $display("%0t: accepted expected %0b actual %0b",
                     $time, want.accepted, out_data.accepted);
            mismatches++;
          end
        end
      end
    end
    depth <= cursor_reports.size();
  end

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 100ps
// Testbench top for the text console engine: stimulus, idling and verdict.
module tb_top;
  import tce_pkg::*;

  // Watchdog: sized for every request a full scroll or clear plus the longest
  // gap and stall, taken about three times over.
  localparam int CYCLE_LIMIT  = 10_000_000;
  localparam int PHASE_ITEMS  = 400;
  localparam int DRAIN_CYCLES = 20;

  logic       clk;
  logic       rst_n     = 1'b0;
  logic       in_valid  = 1'b0;
  logic       in_stall;
  in_req_t    in_data   = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  out_rsp_t   out_data;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [7:0] cfg_data  = '0;

  int fail_count;
  int pending_count;
  int checked_count;
  int cycle_count = 0;
  int sent        = 0;
  int attr_writes = 0;
  bit calm        = 1'b0;   // set for the last phase: no idling on either side

  text_console_engine u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  tce_console_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_data      (out_data),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .pending_count (pending_count),
    .checked_count (checked_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // Hang guard: give up once the cycle count passes the limit.
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("timeout after %0d cycles, %0d responses pending", cycle_count, pending_count);
    $display("text_console_engine: mismatch");
    $finish;
  end

  // Receiver side: stall in random bursts, none when calm.
  initial begin
    forever begin
      @(posedge clk);
      if (!calm && $urandom_range(7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 15)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  function automatic in_req_t make_req(logic [1:0] op, logic [7:0] ch,
                                       logic [4:0] row, logic [6:0] col);
    in_req_t req;
    req.operation     = op;
    req.char_code     = ch;
    req.target_row    = row;
    req.target_column = col;
    return req;
  endfunction

  // Mostly well-formed console traffic: text runs with line control, cursor
  // moves biased to the bottom row and the right edge so that wraps and
  // scrolls happen often, reads of real cells, and some out-of-range noise.
  // Every field starts out fully random so every bit toggles.
  function automatic in_req_t random_request();
    in_req_t req;
    int      pick;
    int      sel;
    req  = make_req(2'($urandom), 8'($urandom), 5'($urandom), 7'($urandom));
    pick = $urandom_range(99);
    sel  = $urandom_range(99);
    if (pick < 55) begin
      req.operation = OP_PUT;
      if (sel < 65) req.char_code = 8'($urandom_range(8'h20, 8'h7E));
      else if (sel < 73) req.char_code = CH_NEWLINE;
      else if (sel < 78) req.char_code = CH_RETURN;
      else if (sel < 86) req.char_code = CH_BACKSPACE;
    end else if (pick < 70) begin
      req.operation = OP_SET;
      if (sel < 80) begin
        req.target_row    = ($urandom_range(9) < 3) ? 5'd24 : 5'($urandom_range(0, 24));
        req.target_column = ($urandom_range(3) == 0) ? 7'($urandom_range(70, 79))
                                                     : 7'($urandom_range(0, 79));
      end
    end else if (pick < 72) begin
      req.operation = OP_CLEAR;
    end else begin
      req.operation = OP_READ;
      if (sel < 85) begin
        req.target_row    = 5'($urandom_range(0, 24));
        req.target_column = 7'($urandom_range(0, 79));
      end
    end
    return req;
  endfunction

  // Offer one request and hold it until the block takes it. Insert a random
  // idle burst first unless calm.
  task automatic send(input in_req_t req);
    if (!calm && $urandom_range(5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (in_stall);
    sent++;
  endtask

  // Drop valid, wait for every response, then let the block drain.
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_attr(input logic [7:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    attr_writes++;
  endtask

  initial begin
    logic [7:0] attr;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part with the reset attribute. The first request waits out
    // the store sweep after reset through the stall handshake.
    send(make_req(OP_READ, 8'h00, 5'd0, 7'd0));           // reset blank cell
    send(make_req(OP_PUT, 8'h41, 5'd0, 7'd0));
    send(make_req(OP_PUT, 8'h00, 5'd0, 7'd0));            // lowest byte
    send(make_req(OP_PUT, 8'hFF, 5'd0, 7'd0));            // highest byte
    send(make_req(OP_READ, 8'h00, 5'd0, 7'd1));
    send(make_req(OP_PUT, CH_BACKSPACE, 5'd0, 7'd0));     // blank the 0xFF cell
    send(make_req(OP_READ, 8'h00, 5'd0, 7'd2));
    send(make_req(OP_PUT, CH_RETURN, 5'd0, 7'd0));
    send(make_req(OP_PUT, CH_BACKSPACE, 5'd0, 7'd0));     // no-op at column 0
    send(make_req(OP_SET, 8'h00, 5'd24, 7'd79));          // last cell
    send(make_req(OP_PUT, 8'h5A, 5'd0, 7'd0));            // wrap at bottom: scroll
    send(make_req(OP_READ, 8'h00, 5'd23, 7'd79));
    send(make_req(OP_PUT, CH_NEWLINE, 5'd0, 7'd0));       // newline at bottom: scroll
    send(make_req(OP_READ, 8'h00, 5'd22, 7'd79));
    send(make_req(OP_SET, 8'h00, 5'd31, 7'd127));         // both coordinates out
    send(make_req(OP_SET, 8'h00, 5'd25, 7'd0));           // row just out
    send(make_req(OP_SET, 8'h00, 5'd0, 7'd80));           // column just out
    send(make_req(OP_READ, 8'h00, 5'd25, 7'd10));
    send(make_req(OP_READ, 8'h00, 5'd3, 7'd127));
    send(make_req(OP_READ, 8'h00, 5'd24, 7'd79));
    send(make_req(OP_SET, 8'h00, 5'd12, 7'd40));
    send(make_req(OP_PUT, CH_NEWLINE, 5'd0, 7'd0));
    send(make_req(OP_CLEAR, 8'h00, 5'd0, 7'd0));
    send(make_req(OP_READ, 8'h00, 5'd24, 7'd79));
    send(make_req(OP_PUT, 8'h7E, 5'd0, 7'd0));

    // Random phases, each under its own attribute. Every change waits for
    // the block to drain, so the sender pauses until all responses are in.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       attr = 8'hFF;
        1:       attr = 8'h00;
        2:       attr = 8'($urandom);
        default: attr = 8'h1E;
      endcase
      settle();
      write_attr(attr);
      if (phase == 3) calm = 1'b1;
      for (int i = 0; i < PHASE_ITEMS; i++) send(random_request());
    end

    settle();
    $display("sent %0d requests (text, line control, cursor moves, clears, reads,", sent);
    $display("out-of-range coordinates) under %0d attribute writes; %0d responses compared",
             attr_writes, checked_count);
    if (fail_count == 0) begin
      $display("text_console_engine: match");
    end else begin
      $display("text_console_engine: mismatch");
    end
    $finish;
  end

endmodule
